// ===== hdl/mddz_pkg.sv =====
// ============================================================================
// mddz_pkg: shared types and constants of the demapper
// Widths of the fixed-point path, operation codes, register indexes and
// the item record that travels down the pipeline.
// ============================================================================
package mddz_pkg;

	// Sample format and table size.
	localparam int SW         = 16;
	localparam int FRAC       = 13;
	localparam int MAX_POINTS = 16;
	localparam int PIW        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int IDXW       = 4;
	localparam int SLOTW      = 4;
	localparam int CNTW       = 5;

	// Equalizer widths: products, numerator sums and divisor, dividend, quotient, comparison.
	localparam int PW = 2 * SW;
	localparam int DW = PW + 1;
	localparam int NW = PW + FRAC + 2;
	localparam int QW = SW + 1;
	localparam int CW = DW + QW;

	// Distance widths.
	localparam int DSW   = SW + 1;
	localparam int SQW   = 2 * SW;
	localparam int DISTW = SQW + 1;
	localparam int NG    = (MAX_POINTS + 3) / 4;

	// Saturation limits of the sample format.
	localparam logic signed [SW-1:0] SAT_HI = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {1'b1, {(SW-1){1'b0}}};

	// Operation codes.
	localparam logic OP_DEMAP = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	// Register indexes.
	localparam logic REG_COMP   = 1'b0;
	localparam logic REG_POINTS = 1'b1;

	// One item in flight.
	typedef struct packed {
		logic                   op;
		logic                   comp;
		logic                   zero;
		logic [SLOTW-1:0]       slot;
		logic signed [SW-1:0]   a_re;
		logic signed [SW-1:0]   a_im;
		logic signed [SW-1:0]   p_re;
		logic signed [SW-1:0]   p_im;
	} item_t;

endpackage

// ===== hdl/mddz_zf_front.sv =====
// ============================================================================
// mddz_zf_front: equalizer front end
// Forms s * conj(h) and |h|^2, then the rounded dividend and divisor.
// ============================================================================
module mddz_zf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  mddz_pkg::item_t              in_item,
	input  logic signed [mddz_pkg::SW-1:0] in_chan_re,
	input  logic signed [mddz_pkg::SW-1:0] in_chan_im,
	output logic                         valid_s4,
	output mddz_pkg::item_t              item_s4,
	output logic [mddz_pkg::NW-1:0]      num_re_s4,
	output logic [mddz_pkg::NW-1:0]      num_im_s4,
	output logic                         neg_re_s4,
	output logic                         neg_im_s4,
	output logic [mddz_pkg::DW-1:0]      den_s4
);
	import mddz_pkg::*;

	logic                 valid_s1, valid_s2, valid_s3;
	item_t                item_s1, item_s2, item_s3;
	item_t                item_zc;
	logic signed [SW-1:0] cr_s1, ci_s1;
	logic signed [PW-1:0] rr_s2, ii_s2, ir_s2, ri_s2, cc_s2, dd_s2;
	logic signed [DW-1:0] nr_s3, ni_s3;
	logic [PW-1:0]        den_s3;
	logic [PW-1:0]        den_c;
	logic signed [DW-1:0] nr_neg, ni_neg;
	logic [PW-1:0]        mag_re, mag_im;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign den_c  = PW'($unsigned(cc_s2)) + PW'($unsigned(dd_s2));
	assign nr_neg = -nr_s3;
	assign ni_neg = -ni_s3;
	assign mag_re = nr_s3[DW-1] ? nr_neg[PW-1:0] : nr_s3[PW-1:0];
	assign mag_im = ni_s3[DW-1] ? ni_neg[PW-1:0] : ni_s3[PW-1:0];

	// Zero-channel flag joins the item on its way to stage three.
	always_comb begin
		item_zc      = item_s2;
		item_zc.zero = item_s2.comp && (den_c == '0);
	end

	// Capture, products, sums, then dividend and divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			cr_s1   <= in_chan_re;
			ci_s1   <= in_chan_im;

			item_s2 <= item_s1;
			rr_s2   <= item_s1.a_re * cr_s1;
			ii_s2   <= item_s1.a_im * ci_s1;
			ir_s2   <= item_s1.a_im * cr_s1;
			ri_s2   <= item_s1.a_re * ci_s1;
			cc_s2   <= cr_s1 * cr_s1;
			dd_s2   <= ci_s1 * ci_s1;

			item_s3      <= item_zc;
			nr_s3        <= {rr_s2[PW-1], rr_s2} + {ii_s2[PW-1], ii_s2};
			ni_s3        <= {ir_s2[PW-1], ir_s2} - {ri_s2[PW-1], ri_s2};
			den_s3       <= den_c;

			item_s4   <= item_s3;
			neg_re_s4 <= nr_s3[DW-1];
			neg_im_s4 <= ni_s3[DW-1];
			num_re_s4 <= {{(NW-PW-FRAC-1){1'b0}}, mag_re, {(FRAC+1){1'b0}}}
				+ {{(NW-PW){1'b0}}, den_s3};
			num_im_s4 <= {{(NW-PW-FRAC-1){1'b0}}, mag_im, {(FRAC+1){1'b0}}}
				+ {{(NW-PW){1'b0}}, den_s3};
			den_s4    <= {den_s3, 1'b0};
		end
	end

endmodule

// ===== hdl/mddz_zf_div.sv =====
// ============================================================================
// mddz_zf_div: pipelined restoring divider for both sample components
// An overflow check, one quotient bit per stage, then sign and
// saturation; the equalized sample replaces the raw one where asked.
// ============================================================================
module mddz_zf_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  mddz_pkg::item_t         in_item,
	input  logic [mddz_pkg::NW-1:0] in_num_re,
	input  logic [mddz_pkg::NW-1:0] in_num_im,
	input  logic                    in_neg_re,
	input  logic                    in_neg_im,
	input  logic [mddz_pkg::DW-1:0] in_den,
	output logic                    valid_sf,
	output mddz_pkg::item_t         item_sf
);
	import mddz_pkg::*;

	logic          valid_s [QW+1];
	item_t         item_s  [QW+1];
	logic [NW-1:0] rem_re_s[QW+1];
	logic [NW-1:0] rem_im_s[QW+1];
	logic [QW-1:0] q_re_s  [QW+1];
	logic [QW-1:0] q_im_s  [QW+1];
	logic [DW-1:0] den_s   [QW+1];
	logic          neg_re_s[QW+1];
	logic          neg_im_s[QW+1];
	logic          ovf_re_s[QW+1];
	logic          ovf_im_s[QW+1];
	logic [CW-1:0] den_top;
	item_t         item_eq;

	assign den_top = {{QW{1'b0}}, in_den} << QW;

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QW; j++) valid_s[j] <= 1'b0;
			valid_sf <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int j = 1; j <= QW; j++) valid_s[j] <= valid_s[j-1];
			valid_sf <= valid_s[QW];
		end
	end

	// Overflow check: a quotient of 2^QW or more saturates either way.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s[0]   <= in_item;
			rem_re_s[0] <= in_num_re;
			rem_im_s[0] <= in_num_im;
			q_re_s[0]   <= '0;
			q_im_s[0]   <= '0;
			den_s[0]    <= in_den;
			neg_re_s[0] <= in_neg_re;
			neg_im_s[0] <= in_neg_im;
			ovf_re_s[0] <= {{(CW-NW){1'b0}}, in_num_re} >= den_top;
			ovf_im_s[0] <= {{(CW-NW){1'b0}}, in_num_im} >= den_top;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar j = 1; j <= QW; j++) begin : g_step
		localparam int K = QW - j;
		logic [CW-1:0] dsh, rre, rim;
		assign dsh = {{QW{1'b0}}, den_s[j-1]} << K;
		assign rre = {{(CW-NW){1'b0}}, rem_re_s[j-1]};
		assign rim = {{(CW-NW){1'b0}}, rem_im_s[j-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				item_s[j]   <= item_s[j-1];
				den_s[j]    <= den_s[j-1];
				neg_re_s[j] <= neg_re_s[j-1];
				neg_im_s[j] <= neg_im_s[j-1];
				ovf_re_s[j] <= ovf_re_s[j-1];
				ovf_im_s[j] <= ovf_im_s[j-1];
				if (rre >= dsh) begin
					rem_re_s[j] <= NW'(rre - dsh);
					q_re_s[j]   <= q_re_s[j-1] | (QW'(1) << K);
				end else begin
					rem_re_s[j] <= rem_re_s[j-1];
					q_re_s[j]   <= q_re_s[j-1];
				end
				if (rim >= dsh) begin
					rem_im_s[j] <= NW'(rim - dsh);
					q_im_s[j]   <= q_im_s[j-1] | (QW'(1) << K);
				end else begin
					rem_im_s[j] <= rem_im_s[j-1];
					q_im_s[j]   <= q_im_s[j-1];
				end
			end
		end
	end

	// Sign and saturation of one quotient.
	function automatic logic signed [SW-1:0] sat_q(logic [QW-1:0] q, logic neg, logic ovf);
		logic [QW-1:0] nq;
		nq = -q;
		if (!neg) begin
			if (ovf || q > QW'(SAT_HI)) return SAT_HI;
			return q[SW-1:0];
		end
		if (ovf || q > {1'b0, SAT_LO}) return SAT_LO;
		return nq[SW-1:0];
	endfunction

	// Equalized sample replaces the raw one on a compensated demap with a nonzero channel.
	always_comb begin
		item_eq = item_s[QW];
		if (item_s[QW].comp && !item_s[QW].zero && item_s[QW].op == OP_DEMAP) begin
			item_eq.a_re = sat_q(q_re_s[QW], neg_re_s[QW], ovf_re_s[QW]);
			item_eq.a_im = sat_q(q_im_s[QW], neg_im_s[QW], ovf_im_s[QW]);
		end
	end

	// Final stage.
	always_ff @(posedge clk) begin
		if (en) begin
			item_sf <= item_eq;
		end
	end

endmodule

// ===== hdl/mddz_search.sv =====
// ============================================================================
// mddz_search: constellation table and nearest-point search
// Loads write the table in order with the demaps; distances are squared,
// summed, then reduced through a registered two-level minimum tree.
// ============================================================================
module mddz_search (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  mddz_pkg::item_t           in_item,
	input  logic [mddz_pkg::CNTW-1:0] points_in_use,
	output logic                      valid_s4,
	output mddz_pkg::item_t           item_s4,
	output logic [mddz_pkg::PIW-1:0]  idx_s4
);
	import mddz_pkg::*;

	logic signed [SW-1:0] tab_re_q[MAX_POINTS];
	logic signed [SW-1:0] tab_im_q[MAX_POINTS];
	logic                 valid_s1, valid_s2, valid_s3;
	item_t                item_s1, item_s2, item_s3;
	logic [SQW-1:0]       sq_re_s1[MAX_POINTS];
	logic [SQW-1:0]       sq_im_s1[MAX_POINTS];
	logic [DISTW-1:0]     dist_s2 [MAX_POINTS];
	logic                 act_s2  [MAX_POINTS];
	logic [DISTW-1:0]     gd_s3   [NG];
	logic [PIW-1:0]       gi_s3   [NG];
	logic                 ga_s3   [NG];
	logic [PIW:0]         cnt;

	// Searched point count, clamped to one and to the table size.
	always_comb begin
		if (points_in_use == '0) cnt = (PIW+1)'(1);
		else if (int'(points_in_use) >= MAX_POINTS) cnt = (PIW+1)'(MAX_POINTS);
		else cnt = (PIW+1)'(points_in_use);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Table write by a load item.
	always_ff @(posedge clk) begin
		if (en && in_valid && in_item.op == OP_LOAD && int'(in_item.slot) < MAX_POINTS) begin
			tab_re_q[PIW'(in_item.slot)] <= in_item.p_re;
			tab_im_q[PIW'(in_item.slot)] <= in_item.p_im;
		end
	end

	// Squared component distances against every point.
	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_pt
		logic signed [DSW-1:0]   dre, dim;
		logic signed [2*DSW-1:0] pre, pim;
		assign dre = {in_item.a_re[SW-1], in_item.a_re} - {tab_re_q[i][SW-1], tab_re_q[i]};
		assign dim = {in_item.a_im[SW-1], in_item.a_im} - {tab_im_q[i][SW-1], tab_im_q[i]};
		assign pre = dre * dre;
		assign pim = dim * dim;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_re_s1[i] <= pre[SQW-1:0];
				sq_im_s1[i] <= pim[SQW-1:0];
				dist_s2[i]  <= {1'b0, sq_re_s1[i]} + {1'b0, sq_im_s1[i]};
				act_s2[i]   <= i < int'(cnt);
			end
		end
	end

	// Minimum inside groups of four, first index on ties.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			for (int g = 0; g < NG; g++) begin
				logic [DISTW-1:0] bd;
				logic [PIW-1:0]   bi;
				logic             ba;
				bd = '0;
				bi = '0;
				ba = 1'b0;
				for (int m = 0; m < 4; m++) begin
					if (4 * g + m < MAX_POINTS) begin
						if (act_s2[4*g+m] && (!ba || dist_s2[4*g+m] < bd)) begin
							bd = dist_s2[4*g+m];
							bi = PIW'(4 * g + m);
							ba = 1'b1;
						end
					end
				end
				gd_s3[g] <= bd;
				gi_s3[g] <= bi;
				ga_s3[g] <= ba;
			end
		end
	end

	// Minimum across the groups.
	always_ff @(posedge clk) begin
		if (en) begin
			logic [DISTW-1:0] bd;
			logic [PIW-1:0]   bi;
			logic             ba;
			bd = '0;
			bi = '0;
			ba = 1'b0;
			for (int g = 0; g < NG; g++) begin
				if (ga_s3[g] && (!ba || gd_s3[g] < bd)) begin
					bd = gd_s3[g];
					bi = gi_s3[g];
					ba = 1'b1;
				end
			end
			item_s4 <= item_s3;
			idx_s4  <= bi;
		end
	end

endmodule

// ===== hdl/min_distance_demapper_zf.sv =====
// ============================================================================
// min_distance_demapper_zf: zero-forcing equalizer and hard QAM demapper
// Divides each sample by its channel response when enabled, then returns the
// index of the nearest loaded constellation point.
//
// Channel   Signals                            Item
// s_*       s_tvalid s_tready s_tdata s_tuser  load or demap request
// m_*       m_tvalid m_tready m_tdata m_tuser  nearest index, zero flag
// wr_*      wr_en wr_index wr_data             register write
//
// One item is accepted every cycle while the pipeline is not held; a demap
// result passes through 28 register stages: four in the front end,
// the entry stage, the 17 one-bit stages and the final stage of the divider,
// four in the search and the output register. Loads produce no result.
// The whole pipeline advances together and holds while the output register
// is full and not taken, so nothing is lost or repeated.
// Reset clears valid bits and the compensation flag and sets the point count
// to 16; the point table is not cleared.
// ============================================================================
module min_distance_demapper_zf (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// sample_re, sample_im, chan_re, chan_im, point_slot, point_re, point_im, pad
	input  logic [103:0]              s_tdata,
	// op
	input  logic [0:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// symbol_index, pad
	output logic [7:0]                m_tdata,
	// zero_channel
	output logic [0:0]                m_tuser,
	input  logic                      wr_en,
	input  logic [0:0]                wr_index,
	input  logic [mddz_pkg::CNTW-1:0] wr_data
);
	import mddz_pkg::*;

	logic             comp_q;
	logic [CNTW-1:0]  points_q;
	logic             en;
	item_t            in_item;
	logic             f_valid;
	item_t            f_item;
	logic [NW-1:0]    f_num_re, f_num_im;
	logic             f_neg_re, f_neg_im;
	logic [DW-1:0]    f_den;
	logic             d_valid;
	item_t            d_item;
	logic             r_valid;
	item_t            r_item;
	logic [PIW-1:0]   r_idx;
	logic [IDXW-1:0]  idx_q;
	logic             zero_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q   <= 1'b0;
			points_q <= CNTW'(16);
		end else if (wr_en) begin
			case (wr_index)
				REG_COMP:   comp_q   <= wr_data[0];
				REG_POINTS: points_q <= wr_data;
				default:    ;
			endcase
		end
	end

	// Whole pipeline moves unless the output register is held.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		in_item.op   = s_tuser[0];
		in_item.comp = comp_q;
		in_item.zero = 1'b0;
		in_item.a_re = s_tdata[15:0];
		in_item.a_im = s_tdata[31:16];
		in_item.slot = s_tdata[67:64];
		in_item.p_re = s_tdata[83:68];
		in_item.p_im = s_tdata[99:84];
	end

	mddz_zf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.in_item    (in_item),
		.in_chan_re (s_tdata[47:32]),
		.in_chan_im (s_tdata[63:48]),
		.valid_s4   (f_valid),
		.item_s4    (f_item),
		.num_re_s4  (f_num_re),
		.num_im_s4  (f_num_im),
		.neg_re_s4  (f_neg_re),
		.neg_im_s4  (f_neg_im),
		.den_s4     (f_den)
	);

	mddz_zf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_item   (f_item),
		.in_num_re (f_num_re),
		.in_num_im (f_num_im),
		.in_neg_re (f_neg_re),
		.in_neg_im (f_neg_im),
		.in_den    (f_den),
		.valid_sf  (d_valid),
		.item_sf   (d_item)
	);

	mddz_search u_search (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (d_valid),
		.in_item       (d_item),
		.points_in_use (points_q),
		.valid_s4      (r_valid),
		.item_s4       (r_item),
		.idx_s4        (r_idx)
	);

	// Output register: only demap items leave; a zero channel forces index 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= r_valid && r_item.op == OP_DEMAP;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_q  <= r_item.zero ? '0 : IDXW'(r_idx);
			zero_q <= r_item.zero;
		end
	end

	assign m_tdata = {{(8-IDXW){1'b0}}, idx_q};
	assign m_tuser = zero_q;

endmodule

// ===== verif/mddz_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mddz_checker: prediction and comparison for the demapper
// Watches the input, output and register-write channels, keeps its own copy
// of the point table and the registers, predicts the index and flag of every
// demap item, and compares them with what the block returns.
// ============================================================================
module mddz_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [103:0]              s_tdata,
	input  logic [0:0]                s_tuser,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [7:0]                m_tdata,
	input  logic [0:0]                m_tuser,
	input  logic                      wr_en,
	input  logic [0:0]                wr_index,
	input  logic [mddz_pkg::CNTW-1:0] wr_data,
	output int                        fail_count,
	output int                        pending
);
	import mddz_pkg::*;

	typedef struct packed {
		logic [IDXW-1:0] index;
		logic            zero;
	} decision_t;

	logic signed [SW-1:0] table_re [MAX_POINTS];
	logic signed [SW-1:0] table_im [MAX_POINTS];
	logic                 comp_on;
	logic [CNTW-1:0]      search_count;
	decision_t            decisions [$];

	assign pending = decisions.size();

	// Scaled division with rounding half away from zero and saturation.
	function automatic longint equalize_part(longint num, longint den);
		longint n;
		longint q;
		n = (num < 0 ? -num : num) <<< (FRAC + 1);
		q = (n + den) / (den * 2);
		if (num >= 0)
			return (q > 32767) ? 32767 : q;
		return (q > 32768) ? -32768 : -q;
	endfunction

	// Nearest point search over the active part of the table.
	function automatic decision_t nearest_point(logic [103:0] d);
		decision_t res;
		longint sr, si, cr, ci, den, nr, ni, dsq, best_dist, dr, di;
		int count;
		sr = longint'($signed(d[15:0]));
		si = longint'($signed(d[31:16]));
		cr = longint'($signed(d[47:32]));
		ci = longint'($signed(d[63:48]));
		res = '0;
		if (comp_on) begin
			den = cr * cr + ci * ci;
			if (den == 0) begin
				res.zero = 1'b1;
				return res;
			end
			nr = sr * cr + si * ci;
			ni = si * cr - sr * ci;
			sr = equalize_part(nr, den);
			si = equalize_part(ni, den);
		end
		count = search_count;
		if (count < 1) count = 1;
		if (count > MAX_POINTS) count = MAX_POINTS;
		best_dist = -1;
		for (int i = 0; i < count; i++) begin
			dr = sr - longint'(table_re[i]);
			di = si - longint'(table_im[i]);
			dsq = dr * dr + di * di;
			if (best_dist < 0 || dsq < best_dist) begin
				best_dist = dsq;
				res.index = i[IDXW-1:0];
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decision_t want;
		if (!arst_n) begin
			comp_on = 1'b0;
			search_count = 5'd16;
			fail_count = 0;
			decisions.delete();
		end else begin
			// Register writes.
			if (wr_en) begin
				if (wr_index == REG_COMP) comp_on = wr_data[0];
				else search_count = wr_data;
			end
			// Accepted input items.
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == OP_LOAD) begin
					table_re[s_tdata[67:64]] = s_tdata[83:68];
					table_im[s_tdata[67:64]] = s_tdata[99:84];
				end else begin
					decisions = {decisions, nearest_point(s_tdata)};
				end
			end
			// Accepted results.
			if (m_tvalid && m_tready) begin
				if (decisions.size() == 0) begin
					$error("result with no expectation: symbol_index %0d", m_tdata[3:0]);
					fail_count++;
				end else begin
					want = decisions.pop_front();
					if (m_tdata[3:0] !== want.index) begin
						$error("symbol_index: expected %0d, actual %0d", want.index,
							m_tdata[3:0]);
						fail_count++;
					end
					if (m_tuser[0] !== want.zero) begin
						$error("zero_channel: expected %0d, actual %0d", want.zero,
							m_tuser[0]);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb_min_distance_demapper_zf.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_min_distance_demapper_zf: stimulus and verdict for the demapper
// Loads constellations, runs directed and random demap items through both
// register settings and several point counts, with random idling on both
// sides; a separate checker predicts and compares every result.
// ============================================================================
module tb_min_distance_demapper_zf;
	import mddz_pkg::*;

	localparam int LATENCY = 40;
	localparam int CYCLE_LIMIT = 200000;

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [103:0]    s_tdata;
	logic [0:0]      s_tuser;
	logic            m_tvalid;
	logic            m_tready;
	logic [7:0]      m_tdata;
	logic [0:0]      m_tuser;
	logic            wr_en;
	logic [0:0]      wr_index;
	logic [CNTW-1:0] wr_data;
	int              fail_count;
	int              pending;
	int              cycles = 0;
	bit              calm;
	logic [15:0]     grid [4];

	min_distance_demapper_zf uut (.*);

	mddz_checker checker_i (.*);

	// Clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver stall.
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 18);
	end

	// Send one item and wait for its acceptance.
	task automatic send_item(logic op, logic [103:0] payload);
		if (!calm) begin
			while ($urandom_range(99) < 18) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= payload;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic load_point(logic [3:0] slot, logic [15:0] re, logic [15:0] im);
		send_item(OP_LOAD, {4'h0, im, re, slot, 64'($urandom) << 32 | 64'($urandom)});
	endtask

	task automatic demap(logic [15:0] sr, logic [15:0] si, logic [15:0] cr, logic [15:0] ci);
		send_item(OP_DEMAP, {4'($urandom), 36'({$urandom, $urandom}), ci, cr, si, sr});
	endtask

	// Wait until all results are in, then write a register.
	task automatic write_reg(logic [0:0] idx, logic [CNTW-1:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		wr_en    <= 1'b0;
	endtask

	function automatic logic [15:0] rand_word();
		case ($urandom_range(5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return grid[$urandom_range(3)] + 16'($urandom_range(600)) - 16'd300;
			3: return 16'($urandom_range(400)) - 16'd200;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int n;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		wr_en    = 1'b0;
		wr_index = '0;
		wr_data  = '0;
		calm     = 1'b0;
		grid     = '{16'hDA00, 16'hF200, 16'h0E00, 16'h2600};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole table with a 16-point grid.
		for (int i = 0; i < 16; i++)
			load_point(i[3:0], grid[i % 4], grid[i / 4]);

		// Directed: extremes, ties and a raw search.
		demap(16'h7FFF, 16'h7FFF, 16'h0, 16'h0);
		demap(16'h8000, 16'h8000, 16'h0, 16'h0);
		demap(16'h0000, 16'h0000, 16'hFFFF, 16'h8000);
		demap(16'h0000, 16'h0E00, 16'h0, 16'h0);

		// Directed: zero forcing, zero channel, saturation, rounding.
		write_reg(REG_COMP, 5'd1);
		demap(16'h2600, 16'h0E00, 16'h0000, 16'h0000);
		demap(16'h2000, 16'h2000, 16'h2000, 16'h0000);
		demap(16'h7FFF, 16'h8000, 16'h0001, 16'h0000);
		demap(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
		demap(16'h0001, 16'h0000, 16'h0003, 16'h0000);
		demap(16'hFFFF, 16'h0000, 16'h8000, 16'h8000);
		demap(16'h0E00, 16'hF200, 16'h0000, 16'h2000);

		// Random phases over several settings.
		for (int phase = 0; phase < 8; phase++) begin
			write_reg(REG_COMP, 5'(phase & 1));
			case (phase >> 1)
				0: write_reg(REG_POINTS, 5'd16);
				1: write_reg(REG_POINTS, 5'd2);
				2: write_reg(REG_POINTS, 5'd4);
				default: write_reg(REG_POINTS, ($urandom_range(1) != 0) ? 5'd0 : 5'd31);
			endcase
			calm = (phase == 5);
			for (n = 0; n < 80; n++) begin
				if ($urandom_range(99) < 8)
					load_point(4'($urandom), rand_word(), rand_word());
				else if ((phase & 1) && $urandom_range(99) < 60)
					demap(rand_word(), rand_word(), 16'h2000 + 16'($urandom_range(4000)) -
						16'd2000, 16'($urandom_range(4000)) - 16'd2000);
				else
					demap(rand_word(), rand_word(), rand_word(), rand_word());
			end
		end

		// Drain.
		s_tvalid <= 1'b0;
		calm = 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mddz_pkg.sv
hdl/mddz_zf_front.sv
hdl/mddz_zf_div.sv
hdl/mddz_search.sv
hdl/min_distance_demapper_zf.sv
verif/mddz_checker.sv
verif/tb_min_distance_demapper_zf.sv
